[design/lsd_decimal_radix_sorter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decimal radix sorter
// Shared forms for the concurrent checks on the sorter's ports.
// ----------------------------------------------------------------------------
`ifndef LSD_DECIMAL_RADIX_SORTER_ASSERT_SVH
`define LSD_DECIMAL_RADIX_SORTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSDRS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSDRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lsdrs_pkg.sv]
// ----------------------------------------------------------------------------
// lsdrs_pkg
// Types and fixed constants of the decimal radix sorter.
// ----------------------------------------------------------------------------
package lsdrs_pkg;

    localparam int VALUE_W     = 31;
    localparam int QUOT_W      = 31;
    localparam int DIGIT_W     = 4;
    localparam int DATA_W      = 32;
    localparam int RADIX       = 10;
    localparam logic [DIGIT_W-1:0] LAST_DIGIT = 4'd9;

    // q / 10 == (q * 0xCCCCCCCD) >> 35 for every q below 2^32.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          PROD_W      = QUOT_W + 32;

    // One store entry: the value itself, its quotient by the current digit
    // weight and the digit found in the counting sweep.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [QUOT_W-1:0]  quot;
        logic [DIGIT_W-1:0] digit;
    } lsdrs_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_CHK,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_EMIT_RD,
        ST_EMIT_CAP,
        ST_EMIT_HOLD
    } lsdrs_state_t;

endpackage

[design/lsd_decimal_radix_sorter.sv]
// ----------------------------------------------------------------------------
// lsd_decimal_radix_sorter
// Stable least-significant-digit decimal radix sorter over a stored set.
// ----------------------------------------------------------------------------
// Usage: values arrive on the s_ channel, one per request, the value in
// s_tdata[30:0]. The request with s_tlast high closes the set. Up to CAPACITY
// values are kept; further ones are discarded and every result of that set
// then carries m_tuser high. A discarded closing request still closes the set.
// Once closed, the block runs one decimal pass per digit of the largest value
// (at most ten). Each pass consists of a counting sweep through the store
// memory with a two-stage divide-by-ten pipeline, a nine-step prefix sum
// over the digit counters, and a back-to-front scatter into the second
// memory bank, one entry a cycle on its single write port.
// The set is then sent on the m_ channel in ascending order, m_tlast on the
// final value; the next result is read only after the current one is taken.
// s_tready is low from the closing request until the last result has been
// taken. A stall on m_tready simply holds the current result in its output
// register.
// Reset clears the control state and empties the set; the memories are not
// cleared, as only entries written for the current set are ever read.
module lsd_decimal_radix_sorter #(
    parameter int CAPACITY = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lsdrs_pkg::DATA_W-1:0] s_tdata,   // [30:0] value, [31] zero
    input  logic                         s_tlast,   // last_item
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lsdrs_pkg::DATA_W-1:0] m_tdata,   // [30:0] sorted_value, [31] zero
    output logic                         m_tlast,   // last_result
    output logic                         m_tuser    // [0] dropped
);
    import lsdrs_pkg::*;

    // Address width for the stores and count width that can hold CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    lsdrs_state_t state_reg, state_next;

    // Set bookkeeping. largest_reg holds the largest quotient by the
    // current digit weight; it reaches zero once every digit is sorted.
    logic                sel_reg;
    logic [CW-1:0]       count_reg;
    logic [QUOT_W-1:0]   largest_reg;
    logic                drop_reg;
    logic [CW-1:0]       idx_reg;
    logic [DIGIT_W-1:0]  dig_reg;
    logic [QUOT_W-1:0]   lmax_reg;

    // Digit counters, later the running end positions of each digit bucket.
    logic [CW-1:0]       cnt_reg [RADIX];

    // Two banks of the store; the role of each swaps after every scatter.
    lsdrs_entry_t        bank0_mem [CAPACITY];
    lsdrs_entry_t        bank1_mem [CAPACITY];
    lsdrs_entry_t        rd0_reg, rd1_reg, rd_entry;

    // Counting pipeline: read data returns in stage 1, the product of the
    // quotient and the reciprocal of ten is registered in stage 2.
    logic                p1_v_reg, p2_v_reg;
    logic [AW-1:0]       p1_addr_reg, p2_addr_reg;
    logic [VALUE_W-1:0]  p2_value_reg;
    logic [QUOT_W-1:0]   p2_quot_reg;
    logic [PROD_W-1:0]   p2_prod_reg;
    logic [QUOT_W-1:0]   quot_next;
    logic [QUOT_W-1:0]   rem_full;
    logic [DIGIT_W-1:0]  digit_now;
    logic [CW-1:0]       scat_pos;

    // Output register.
    logic                m_valid_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic                m_last_reg;
    logic                m_drop_reg;

    // Memory access controls.
    logic                rd_issue;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic                mem_wbank;
    logic [AW-1:0]       mem_waddr;
    lsdrs_entry_t        mem_wdata;

    logic                in_acc;
    logic                store_full;
    logic [VALUE_W-1:0]  s_value;

    assign s_value    = s_tdata[VALUE_W-1:0];
    assign in_acc     = s_tvalid && s_tready;
    assign store_full = (count_reg == CW'(CAPACITY));
    assign rd_entry   = sel_reg ? rd1_reg : rd0_reg;

    // Divide-by-ten result and the digit it leaves behind.
    assign quot_next = QUOT_W'(p2_prod_reg[PROD_W-1:RECIP_SHIFT]);
    assign rem_full  = p2_quot_reg - ((quot_next << 3) + (quot_next << 1));
    assign digit_now = rem_full[DIGIT_W-1:0];
    assign scat_pos  = cnt_reg[rd_entry.digit] - CW'(1);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(DATA_W - VALUE_W){1'b0}}, m_value_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_drop_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = ST_PASS_CHK;
                end
            end
            ST_PASS_CHK: begin
                state_next = (largest_reg == '0) ? ST_EMIT_RD : ST_COUNT;
            end
            ST_COUNT: begin
                if (idx_reg == count_reg && !p1_v_reg && !p2_v_reg) begin
                    state_next = ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                if (dig_reg == LAST_DIGIT) begin
                    state_next = ST_SCATTER;
                end
            end
            ST_SCATTER: begin
                if (idx_reg == '0 && !p1_v_reg) begin
                    state_next = ST_PASS_CHK;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_CAP;
            ST_EMIT_CAP: state_next = ST_EMIT_HOLD;
            ST_EMIT_HOLD: begin
                if (m_tready) begin
                    state_next = m_last_reg ? ST_LOAD : ST_EMIT_CAP;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Memory controls and input handshake.
    always_comb begin
        s_tready  = 1'b0;
        rd_issue  = 1'b0;
        rd_addr   = idx_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_wbank = sel_reg;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = '{value: s_value, quot: s_value, digit: '0};
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                mem_we   = in_acc && !store_full;
            end
            ST_COUNT: begin
                rd_issue  = (idx_reg < count_reg);
                mem_we    = p2_v_reg;
                mem_waddr = p2_addr_reg;
                mem_wdata = '{value: p2_value_reg, quot: quot_next, digit: digit_now};
            end
            ST_SCATTER: begin
                rd_issue  = (idx_reg != '0);
                rd_addr   = AW'(idx_reg - CW'(1));
                mem_we    = p1_v_reg;
                mem_wbank = ~sel_reg;
                mem_waddr = scat_pos[AW-1:0];
                mem_wdata = rd_entry;
            end
            ST_EMIT_RD: begin
                rd_issue = 1'b1;
            end
            ST_EMIT_HOLD: begin
                rd_issue = m_tready && !m_last_reg;
            end
            default: begin
                rd_issue = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            sel_reg     <= 1'b0;
            count_reg   <= '0;
            largest_reg <= '0;
            drop_reg    <= 1'b0;
            idx_reg     <= '0;
            dig_reg     <= '0;
            lmax_reg    <= '0;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            p1_v_reg  <= rd_issue;
            p2_v_reg  <= p1_v_reg && (state_reg == ST_COUNT);
            case (state_reg)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (!store_full) begin
                            count_reg <= count_reg + CW'(1);
                            if (QUOT_W'(s_value) > largest_reg) begin
                                largest_reg <= QUOT_W'(s_value);
                            end
                        end else begin
                            drop_reg <= 1'b1;
                        end
                    end
                end
                ST_PASS_CHK: begin
                    idx_reg  <= '0;
                    lmax_reg <= '0;
                end
                ST_COUNT: begin
                    if (rd_issue) begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    if (p2_v_reg && quot_next > lmax_reg) begin
                        lmax_reg <= quot_next;
                    end
                    if (state_next == ST_PREFIX) begin
                        largest_reg <= lmax_reg;
                        dig_reg     <= DIGIT_W'(1);
                    end
                end
                ST_PREFIX: begin
                    dig_reg <= dig_reg + DIGIT_W'(1);
                    if (state_next == ST_SCATTER) begin
                        idx_reg <= count_reg;
                    end
                end
                ST_SCATTER: begin
                    if (rd_issue) begin
                        idx_reg <= idx_reg - CW'(1);
                    end
                    if (state_next == ST_PASS_CHK) begin
                        sel_reg <= ~sel_reg;
                    end
                end
                ST_EMIT_RD: begin
                    idx_reg <= idx_reg + CW'(1);
                end
                ST_EMIT_CAP: begin
                    m_valid_reg <= 1'b1;
                end
                ST_EMIT_HOLD: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            count_reg   <= '0;
                            largest_reg <= '0;
                            drop_reg    <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg + CW'(1);
                        end
                    end
                end
                default: begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Pipeline payload, digit counters and output data.
    always_ff @(posedge aclk) begin
        p1_addr_reg  <= rd_addr;
        p2_addr_reg  <= p1_addr_reg;
        p2_value_reg <= rd_entry.value;
        p2_quot_reg  <= rd_entry.quot;
        p2_prod_reg  <= PROD_W'(rd_entry.quot) * PROD_W'(RECIP_10);

        case (state_reg)
            ST_PASS_CHK: begin
                for (int k = 0; k < RADIX; k++) begin
                    cnt_reg[k] <= '0;
                end
            end
            ST_COUNT: begin
                if (p2_v_reg) begin
                    cnt_reg[digit_now] <= cnt_reg[digit_now] + CW'(1);
                end
            end
            ST_PREFIX: begin
                cnt_reg[dig_reg] <= cnt_reg[dig_reg] + cnt_reg[dig_reg - DIGIT_W'(1)];
            end
            ST_SCATTER: begin
                if (p1_v_reg) begin
                    cnt_reg[rd_entry.digit] <= scat_pos;
                end
            end
            ST_EMIT_CAP: begin
                m_value_reg <= rd_entry.value;
                m_last_reg  <= (idx_reg == count_reg);
                m_drop_reg  <= drop_reg;
            end
            default: begin
                m_last_reg <= m_last_reg;
            end
        endcase
    end

    // Store bank 0.
    always_ff @(posedge aclk) begin
        if (mem_we && !mem_wbank) begin
            bank0_mem[mem_waddr] <= mem_wdata;
        end
        rd0_reg <= bank0_mem[rd_addr];
    end

    // Store bank 1.
    always_ff @(posedge aclk) begin
        if (mem_we && mem_wbank) begin
            bank1_mem[mem_waddr] <= mem_wdata;
        end
        rd1_reg <= bank1_mem[rd_addr];
    end

endmodule

[design/lsdrs_checker.sv]
// ----------------------------------------------------------------------------
// lsdrs_checker
// Port-level checks of the decimal radix sorter, bound to its top level.
// ----------------------------------------------------------------------------
module lsdrs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);
`include "lsd_decimal_radix_sorter_assert.svh"

    // Loading and sending never overlap.
    `LSDRS_ASSERT_SAME(a_no_load_while_sending, aclk, aresetn, m_tvalid, !s_tready, "input ready while a result is pending")

    // A closing request stops intake until the set has been sent.
    `LSDRS_ASSERT_NEXT(a_close_stops_intake, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready && !m_tvalid, "intake continued after the closing request")

    // The last result ends the run.
    `LSDRS_ASSERT_NEXT(a_last_ends_run, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready, "results continued after the last one")

    // A stalled result holds its data.
    `LSDRS_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

endmodule

bind lsd_decimal_radix_sorter lsdrs_checker u_lsdrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
